[rtl/pbsf_pkg.sv]
// Shared types and constants for the projected box screen fraction block.
package pbsf_pkg;

  localparam int DIV_STEPS = 63;
  localparam int PIPE_REGS = DIV_STEPS + 10;
  localparam int LANES = 8;

  localparam logic [1:0] CFG_X_SCALE  = 2'd0;
  localparam logic [1:0] CFG_Y_SCALE  = 2'd1;
  localparam logic [1:0] CFG_X_OFFSET = 2'd2;
  localparam logic [1:0] CFG_Y_OFFSET = 2'd3;

  localparam logic signed [31:0] SCALE_RESET = 32'sd16777216;
  localparam logic signed [63:0] FX_ONE24 = 64'sd16777216;
  localparam logic signed [63:0] FX_LIMIT = 64'sd1152921504606846976;
  localparam logic [16:0] FULL_VIEW = 17'd65536;

  typedef struct packed {
    logic zpos;
    logic zsplit;
  } sel_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [62:0] sh;
  } div_lane_t;

  typedef struct packed {
    sel_t        sel;
    logic [7:0]  qneg;
    logic [31:0] dz0;
    logic [31:0] dz1;
  } div_ctl_t;

  // One restoring division step: brings in the next dividend bit and sets one quotient bit.
  function automatic div_lane_t div_step(div_lane_t a, logic [31:0] d);
    logic [32:0] t;
    logic        qb;
    div_lane_t   r;
    t = {a.rem, a.sh[62]};
    qb = (t >= {1'b0, d});
    r.rem = qb ? 32'(t - {1'b0, d}) : t[31:0];
    r.sh = {a.sh[61:0], qb};
    return r;
  endfunction

endpackage

[rtl/projected_box_screen_fraction_core.sv]
// Top level of the projected box screen fraction pipeline.
//
// Usage: an item is a view-space box given on the in_box_* ports. It is accepted
// at a rising edge where start is high and busy is low. The result, the covered
// fraction of the viewport in unsigned Q1.16, appears on out_view_fraction for
// exactly one cycle with out_strobe high, once the item has left the last pipeline register.
// A new item may be accepted in every cycle, so throughput is one item per cycle.
// The latency is set by the 63-step pipelined restoring dividers, eight lanes
// wide, which divide each projected edge product by the two z extents, plus
// stages for the multiplies, offsets, clamping and the area product.
// The four projection coefficients are to be written through the cfg_ port only while no
// item is in flight; the block itself does not enforce this. They take effect at the next edge.
// busy is high only while rst_n is low. Reset clears the valid bits of the
// pipeline and loads the default coefficients; items in flight are dropped.
// The receiver cannot stall the block, so results are never held back.
module projected_box_screen_fraction_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_box_x_low,
  input  logic signed [31:0] in_box_x_high,
  input  logic signed [31:0] in_box_y_low,
  input  logic signed [31:0] in_box_y_high,
  input  logic signed [31:0] in_box_z_first,
  input  logic signed [31:0] in_box_z_second,
  output logic               out_strobe,
  output logic [16:0]        out_view_fraction,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] x_scale_r, y_scale_r, x_offset_r, y_offset_r;
  logic [pbsf_pkg::PIPE_REGS-1:0] vld_r;
  logic accept;

  assign busy = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r <= pbsf_pkg::SCALE_RESET;
      y_scale_r <= pbsf_pkg::SCALE_RESET;
      x_offset_r <= '0;
      y_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbsf_pkg::CFG_X_SCALE:  x_scale_r <= cfg_data;
        pbsf_pkg::CFG_Y_SCALE:  y_scale_r <= cfg_data;
        pbsf_pkg::CFG_X_OFFSET: x_offset_r <= cfg_data;
        pbsf_pkg::CFG_Y_OFFSET: y_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[pbsf_pkg::PIPE_REGS-2:0], accept};
    end
  end

  // Input register.
  logic signed [31:0] c_r [4];
  logic signed [31:0] z0_r, z1_r;

  always_ff @(posedge clk) begin
    c_r[0] <= in_box_x_low;
    c_r[1] <= in_box_y_low;
    c_r[2] <= in_box_x_high;
    c_r[3] <= in_box_y_high;
    z0_r <= in_box_z_first;
    z1_r <= in_box_z_second;
  end

  // Edge products.
  logic signed [63:0] p_r [4];
  logic signed [31:0] mz0_r, mz1_r;
  pbsf_pkg::sel_t m_sel_r;

  always_ff @(posedge clk) begin
    for (int e = 0; e < 4; e++) begin
      p_r[e] <= 64'(c_r[e]) * 64'(e[0] ? y_scale_r : x_scale_r);
    end
    mz0_r <= z0_r;
    mz1_r <= z1_r;
    m_sel_r.zpos <= ~z0_r[31];
    m_sel_r.zsplit <= ~z1_r[31];
  end

  // Magnitudes for the unsigned dividers.
  logic [62:0] pm_r [4];
  pbsf_pkg::div_ctl_t g_ctl_r;

  always_ff @(posedge clk) begin
    for (int e = 0; e < 4; e++) begin
      pm_r[e] <= p_r[e][63] ? 63'(-p_r[e]) : p_r[e][62:0];
      g_ctl_r.qneg[2*e] <= ~p_r[e][63];
      g_ctl_r.qneg[2*e+1] <= ~p_r[e][63];
    end
    g_ctl_r.dz0 <= 32'(-mz0_r);
    g_ctl_r.dz1 <= 32'(-mz1_r);
    g_ctl_r.sel <= m_sel_r;
  end

  // Pipelined dividers, one quotient bit per stage, lane 2*e+k divides edge e by z k.
  pbsf_pkg::div_lane_t dl_r [pbsf_pkg::DIV_STEPS][pbsf_pkg::LANES];
  pbsf_pkg::div_ctl_t  dc_r [pbsf_pkg::DIV_STEPS];

  for (genvar j = 0; j < pbsf_pkg::DIV_STEPS; j++) begin : g_div
    pbsf_pkg::div_lane_t src [pbsf_pkg::LANES];
    pbsf_pkg::div_ctl_t  src_ctl;
    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < pbsf_pkg::LANES; k++) begin
          src[k].rem = '0;
          src[k].sh = pm_r[k/2];
        end
        src_ctl = g_ctl_r;
      end
    end else begin : g_rest
      always_comb begin
        for (int k = 0; k < pbsf_pkg::LANES; k++) begin
          src[k] = dl_r[j-1][k];
        end
        src_ctl = dc_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < pbsf_pkg::LANES; k++) begin
        dl_r[j][k] <= pbsf_pkg::div_step(src[k], k[0] ? src_ctl.dz1 : src_ctl.dz0);
      end
      dc_r[j] <= src_ctl;
    end
  end

  localparam int LAST = pbsf_pkg::DIV_STEPS - 1;

  // Projected edges with the offset applied.
  logic signed [63:0] e_r [pbsf_pkg::LANES];
  pbsf_pkg::sel_t e_sel_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < pbsf_pkg::LANES; k++) begin
      logic signed [63:0] q, off;
      q = {1'b0, dl_r[LAST][k].sh};
      off = 64'((k/2) % 2 == 1 ? y_offset_r : x_offset_r);
      e_r[k] <= dc_r[LAST].qneg[k] ? q - off : -off - q;
    end
    e_sel_r <= dc_r[LAST].sel;
  end

  // Extremes over the two depths.
  logic signed [63:0] left_r, bottom_r, right_r, top_r;
  pbsf_pkg::sel_t mm_sel_r;

  always_ff @(posedge clk) begin
    left_r <= (e_r[0] <= e_r[1]) ? e_r[0] : e_r[1];
    bottom_r <= (e_r[2] <= e_r[3]) ? e_r[2] : e_r[3];
    right_r <= (e_r[4] <= e_r[5]) ? e_r[5] : e_r[4];
    top_r <= (e_r[6] <= e_r[7]) ? e_r[7] : e_r[6];
    mm_sel_r <= e_sel_r;
  end

  // Clamp to the viewport.
  logic signed [63:0] left_nxt, bottom_nxt, right_nxt, top_nxt;
  logic signed [63:0] lcl_r, bcl_r, rcl_r, tcl_r;
  pbsf_pkg::sel_t cl_sel_r;

  always_comb begin
    left_nxt = (left_r < -pbsf_pkg::FX_ONE24) ? -pbsf_pkg::FX_ONE24 : left_r;
    left_nxt = (left_nxt > pbsf_pkg::FX_LIMIT) ? pbsf_pkg::FX_LIMIT : left_nxt;
    bottom_nxt = (bottom_r < -pbsf_pkg::FX_ONE24) ? -pbsf_pkg::FX_ONE24 : bottom_r;
    bottom_nxt = (bottom_nxt > pbsf_pkg::FX_LIMIT) ? pbsf_pkg::FX_LIMIT : bottom_nxt;
    right_nxt = (right_r > pbsf_pkg::FX_ONE24) ? pbsf_pkg::FX_ONE24 : right_r;
    right_nxt = (right_nxt < -pbsf_pkg::FX_LIMIT) ? -pbsf_pkg::FX_LIMIT : right_nxt;
    top_nxt = (top_r > pbsf_pkg::FX_ONE24) ? pbsf_pkg::FX_ONE24 : top_r;
    top_nxt = (top_nxt < -pbsf_pkg::FX_LIMIT) ? -pbsf_pkg::FX_LIMIT : top_nxt;
  end

  always_ff @(posedge clk) begin
    lcl_r <= left_nxt;
    bcl_r <= bottom_nxt;
    rcl_r <= right_nxt;
    tcl_r <= top_nxt;
    cl_sel_r <= mm_sel_r;
  end

  // Width and height.
  logic signed [63:0] w_r, h_r;
  pbsf_pkg::sel_t wh_sel_r;

  always_ff @(posedge clk) begin
    w_r <= rcl_r - lcl_r;
    h_r <= tcl_r - bcl_r;
    wh_sel_r <= cl_sel_r;
  end

  // Magnitudes, sign test and split into 25-bit halves.
  logic [63:0] aw_nxt, ah_nxt;
  logic [24:0] awl_r, awh_r, ahl_r, ahh_r;
  logic ab_zero_r, ab_big_r;
  pbsf_pkg::sel_t ab_sel_r;

  always_comb begin
    aw_nxt = w_r[63] ? 64'(-w_r) : 64'(w_r);
    ah_nxt = h_r[63] ? 64'(-h_r) : 64'(h_r);
  end

  always_ff @(posedge clk) begin
    ab_zero_r <= (w_r == '0) | (h_r == '0) | (w_r[63] != h_r[63]);
    ab_big_r <= (aw_nxt[63:50] != '0) | (ah_nxt[63:50] != '0);
    awl_r <= aw_nxt[24:0];
    awh_r <= aw_nxt[49:25];
    ahl_r <= ah_nxt[24:0];
    ahh_r <= ah_nxt[49:25];
    ab_sel_r <= wh_sel_r;
  end

  // Partial products of the area.
  logic [49:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic pp_zero_r, pp_big_r;
  pbsf_pkg::sel_t pp_sel_r;

  always_ff @(posedge clk) begin
    pp_ll_r <= 50'(awl_r) * 50'(ahl_r);
    pp_lh_r <= 50'(awl_r) * 50'(ahh_r);
    pp_hl_r <= 50'(awh_r) * 50'(ahl_r);
    pp_hh_r <= 50'(awh_r) * 50'(ahh_r);
    pp_zero_r <= ab_zero_r;
    pp_big_r <= ab_big_r;
    pp_sel_r <= ab_sel_r;
  end

  // Area sum, saturation and result selection.
  logic [99:0] area_nxt;
  logic [16:0] frac_nxt;
  logic [16:0] frac_r;

  always_comb begin
    area_nxt = {pp_hh_r, 50'd0} + {24'd0, ({1'b0, pp_lh_r} + {1'b0, pp_hl_r}), 25'd0}
             + {50'd0, pp_ll_r};
    if (pp_sel_r.zpos) begin
      frac_nxt = '0;
    end else if (pp_sel_r.zsplit) begin
      frac_nxt = pbsf_pkg::FULL_VIEW;
    end else if (pp_zero_r) begin
      frac_nxt = '0;
    end else if (pp_big_r || (area_nxt[99:50] != '0)) begin
      frac_nxt = pbsf_pkg::FULL_VIEW;
    end else begin
      frac_nxt = {1'b0, area_nxt[49:34]};
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

  assign out_strobe = vld_r[pbsf_pkg::PIPE_REGS-1];
  assign out_view_fraction = frac_r;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_view_fraction <= pbsf_pkg::FULL_VIEW)
    else $error("result above full view");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(start && !busy, pbsf_pkg::PIPE_REGS))
    else $error("result strobe does not match an accepted item");

  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(start && !busy && !in_box_z_first[31], pbsf_pkg::PIPE_REGS))
    |-> out_view_fraction == '0)
    else $error("box in front of the eye gave a nonzero fraction");
`endif

endmodule
